FILE: src/gdo_pkg.sv
// gdo_pkg: shared constants, types and calendar helpers for the date offset block
`timescale 1ns / 1ps

package gdo_pkg;

  // calendar limits and field widths
  localparam int unsigned MAX_YEAR  = 9999;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MON_W     = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned OFF_W     = 21;
  localparam int unsigned SERIAL_W  = 22;

  // internal widths: year counter covers the largest offset past MAX_YEAR
  localparam int unsigned YR_W  = $clog2(MAX_YEAR + 3000);
  localparam int unsigned SER_W = $clog2(MAX_YEAR * 366 + 1);
  localparam int unsigned ACC_W = ((SER_W > OFF_W) ? SER_W : OFF_W) + 2;

  // day counts of the 400/100/4/1 year periods
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;
  localparam int unsigned CYC_100Y  = 3;
  localparam int unsigned CYC_4Y    = 24;
  localparam int unsigned CYC_1Y    = 3;
  localparam int unsigned MONTHS    = 12;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Y400,
    ST_Y100,
    ST_Y4,
    ST_Y1,
    ST_MON,
    ST_DAY,
    ST_TGT,
    ST_CHK,
    ST_D400,
    ST_D100,
    ST_D4,
    ST_D1,
    ST_DMON,
    ST_DONE
  } gdo_state_e;

  // result of one request, handed from the core to the output register
  typedef struct packed {
    logic [DAY_W-1:0]    day;
    logic [MON_W-1:0]    month;
    logic [YEAR_W-1:0]   year;
    logic [SERIAL_W-1:0] serial;
    logic                date_valid;
    logic                range_error;
  } gdo_res_t;

  // length of a month, zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] gdo_month_len(input logic [MON_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = '0;
    endcase
    return n;
  endfunction

endpackage

FILE: src/gdo_alu.sv
// gdo_alu: shared add/subtract unit with sign flag for the date sequencer
`timescale 1ns / 1ps

module gdo_alu (
  input  gdo_pkg::acc_t a_i,
  input  gdo_pkg::acc_t b_i,
  input  logic          sub_i,
  output gdo_pkg::acc_t sum_o,
  output logic          neg_o
);
  import gdo_pkg::*;

  // one adder, operand inverted for subtract
  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign neg_o = sum_o[ACC_W-1];

endmodule

FILE: src/gdo_core.sv
// gdo_core: sequencer and datapath registers that step dates through the shared adder
`timescale 1ns / 1ps

module gdo_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [gdo_pkg::DAY_W-1:0]          in_day_i,
  input  logic [gdo_pkg::MON_W-1:0]          in_month_i,
  input  logic [gdo_pkg::YEAR_W-1:0]         in_year_i,
  input  logic signed [gdo_pkg::OFF_W-1:0]   day_offset_i,
  output logic                               res_valid_o,
  input  logic                               res_take_i,
  output gdo_pkg::gdo_res_t                  res_o
);
  import gdo_pkg::*;

  gdo_state_e state_q, state_d;

  logic [DAY_W-1:0]        day_q, day_d;
  logic [MON_W-1:0]        mlim_q, mlim_d;
  logic [MON_W-1:0]        mon_q, mon_d;
  logic signed [OFF_W-1:0] off_q, off_d;
  logic [YR_W-1:0]         yr_q, yr_d;
  logic [SER_W-1:0]        ser_q, ser_d;
  acc_t                    acc_q, acc_d;
  logic [1:0]              n100_q, n100_d;
  logic [4:0]              n4_q, n4_d;
  logic [1:0]              n1_q, n1_d;
  logic                    valid_q, valid_d;
  logic                    rerr_q, rerr_d;

  acc_t                    alu_a, alu_b, alu_sum;
  logic                    alu_sub, alu_neg;
  logic                    leap;
  logic [DAY_W-1:0]        mlen_cur;
  logic                    bad_head;

  gdo_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .neg_o (alu_neg)
  );

  // leap year from the period counts: fourth year of a 4-year block,
  // except the last block of a century unless it is the fourth century
  assign leap     = (n1_q == 2'(CYC_1Y)) &&
                    ((n4_q != 5'(CYC_4Y)) || (n100_q == 2'(CYC_100Y)));
  assign mlen_cur = gdo_month_len(mon_q, leap);
  assign bad_head = (in_year_i == '0) || (32'(in_year_i) > MAX_YEAR) ||
                    (in_month_i == '0) || (32'(in_month_i) > MONTHS);

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    day_d       = day_q;
    mlim_d      = mlim_q;
    mon_d       = mon_q;
    off_d       = off_q;
    yr_d        = yr_q;
    ser_d       = ser_q;
    acc_d       = acc_q;
    n100_d      = n100_q;
    n4_d        = n4_q;
    n1_d        = n1_q;
    valid_d     = valid_q;
    rerr_d      = rerr_q;
    alu_a       = ACC_W'(ser_q);
    alu_b       = '0;
    alu_sub     = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          day_d   = in_day_i;
          mlim_d  = in_month_i;
          off_d   = day_offset_i;
          yr_d    = YR_W'(in_year_i) - YR_W'(1);
          ser_d   = '0;
          n100_d  = '0;
          n4_d    = '0;
          n1_d    = '0;
          rerr_d  = 1'b0;
          valid_d = !bad_head;
          state_d = bad_head ? ST_DONE : ST_Y400;
        end
      end
      // serial number: walk the elapsed years down by period
      ST_Y400: begin
        alu_b = ACC_W'(DAYS_400Y);
        if (yr_q >= YR_W'(400)) begin
          ser_d = alu_sum[SER_W-1:0];
          yr_d  = yr_q - YR_W'(400);
        end else begin
          state_d = ST_Y100;
        end
      end
      ST_Y100: begin
        alu_b = ACC_W'(DAYS_100Y);
        if (yr_q >= YR_W'(100)) begin
          ser_d  = alu_sum[SER_W-1:0];
          yr_d   = yr_q - YR_W'(100);
          n100_d = n100_q + 2'd1;
        end else begin
          state_d = ST_Y4;
        end
      end
      ST_Y4: begin
        alu_b = ACC_W'(DAYS_4Y);
        if (yr_q >= YR_W'(4)) begin
          ser_d = alu_sum[SER_W-1:0];
          yr_d  = yr_q - YR_W'(4);
          n4_d  = n4_q + 5'd1;
        end else begin
          state_d = ST_Y1;
        end
      end
      ST_Y1: begin
        alu_b = ACC_W'(DAYS_1Y);
        if (yr_q != '0) begin
          ser_d = alu_sum[SER_W-1:0];
          yr_d  = yr_q - YR_W'(1);
          n1_d  = n1_q + 2'd1;
        end else if ((day_q == '0) || (day_q > gdo_month_len(mlim_q, leap))) begin
          valid_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          mon_d   = MON_W'(1);
          state_d = ST_MON;
        end
      end
      // add the months before the input month
      ST_MON: begin
        alu_b = ACC_W'(mlen_cur);
        if (mon_q < mlim_q) begin
          ser_d = alu_sum[SER_W-1:0];
          mon_d = mon_q + MON_W'(1);
        end else begin
          state_d = ST_DAY;
        end
      end
      ST_DAY: begin
        alu_b   = ACC_W'(day_q);
        ser_d   = alu_sum[SER_W-1:0];
        state_d = ST_TGT;
      end
      // target serial number
      ST_TGT: begin
        alu_b   = ACC_W'(off_q);
        acc_d   = alu_sum;
        state_d = ST_CHK;
      end
      // before year one, else zero-based day count
      ST_CHK: begin
        alu_a   = acc_q;
        alu_b   = ACC_W'(1);
        alu_sub = 1'b1;
        if (acc_q[ACC_W-1] || (acc_q == '0)) begin
          rerr_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          acc_d   = alu_sum;
          yr_d    = YR_W'(1);
          n100_d  = '0;
          n4_d    = '0;
          n1_d    = '0;
          state_d = ST_D400;
        end
      end
      // result year: peel off periods from the day count
      ST_D400: begin
        alu_a   = acc_q;
        alu_b   = ACC_W'(DAYS_400Y);
        alu_sub = 1'b1;
        if (!alu_neg) begin
          acc_d = alu_sum;
          yr_d  = yr_q + YR_W'(400);
        end else begin
          state_d = ST_D100;
        end
      end
      ST_D100: begin
        alu_a   = acc_q;
        alu_b   = ACC_W'(DAYS_100Y);
        alu_sub = 1'b1;
        if (!alu_neg && (n100_q != 2'(CYC_100Y))) begin
          acc_d  = alu_sum;
          yr_d   = yr_q + YR_W'(100);
          n100_d = n100_q + 2'd1;
        end else begin
          state_d = ST_D4;
        end
      end
      ST_D4: begin
        alu_a   = acc_q;
        alu_b   = ACC_W'(DAYS_4Y);
        alu_sub = 1'b1;
        if (!alu_neg) begin
          acc_d = alu_sum;
          yr_d  = yr_q + YR_W'(4);
          n4_d  = n4_q + 5'd1;
        end else begin
          state_d = ST_D1;
        end
      end
      ST_D1: begin
        alu_a   = acc_q;
        alu_b   = ACC_W'(DAYS_1Y);
        alu_sub = 1'b1;
        if (!alu_neg && (n1_q != 2'(CYC_1Y))) begin
          acc_d = alu_sum;
          yr_d  = yr_q + YR_W'(1);
          n1_d  = n1_q + 2'd1;
        end else if (32'(yr_q) > MAX_YEAR) begin
          rerr_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          mon_d   = MON_W'(1);
          state_d = ST_DMON;
        end
      end
      // result month: peel off whole months
      ST_DMON: begin
        alu_a   = acc_q;
        alu_b   = ACC_W'(mlen_cur);
        alu_sub = 1'b1;
        if (!alu_neg && (mon_q != MON_W'(MONTHS))) begin
          acc_d = alu_sum;
          mon_d = mon_q + MON_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result fields: zeroed on an invalid date; day, month and year zeroed on a range error
  always_comb begin
    res_o             = '0;
    res_o.date_valid  = valid_q;
    res_o.range_error = valid_q && rerr_q;
    if (valid_q) begin
      res_o.serial = SERIAL_W'(ser_q);
    end
    if (valid_q && !rerr_q) begin
      res_o.day   = acc_q[DAY_W-1:0] + DAY_W'(1);
      res_o.month = mon_q;
      res_o.year  = YEAR_W'(yr_q);
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    mlim_q  <= mlim_d;
    mon_q   <= mon_d;
    off_q   <= off_d;
    yr_q    <= yr_d;
    ser_q   <= ser_d;
    acc_q   <= acc_d;
    n100_q  <= n100_d;
    n4_q    <= n4_d;
    n1_q    <= n1_d;
    valid_q <= valid_d;
    rerr_q  <= rerr_d;
  end

endmodule

FILE: src/gregorian_date_offset.sv
// gregorian_date_offset: top level with request handshake and output register
`timescale 1ns / 1ps

// Moves a Gregorian date by a signed day offset and reports the serial day of
// the input date (1 January of year 1 is day 1). One request is worked at a
// time: in_ready_o is high only while the sequencer is idle. The single shared
// adder walks 400-, 100-, 4- and 1-year periods and then months, once to build
// the serial number and once to take the moved date apart, so years near 9999
// take longest; an invalid month or year skips the walk. A finished result sits
// in an output register, so the next request is taken while it waits for
// out_ready_i.
module gregorian_date_offset (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [gdo_pkg::DAY_W-1:0]        in_day_i,
  input  logic [gdo_pkg::MON_W-1:0]        in_month_i,
  input  logic [gdo_pkg::YEAR_W-1:0]       in_year_i,
  input  logic signed [gdo_pkg::OFF_W-1:0] day_offset_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gdo_pkg::DAY_W-1:0]        out_day_o,
  output logic [gdo_pkg::MON_W-1:0]        out_month_o,
  output logic [gdo_pkg::YEAR_W-1:0]       out_year_o,
  output logic [gdo_pkg::SERIAL_W-1:0]     serial_day_o,
  output logic                             date_valid_o,
  output logic                             range_error_o
);
  import gdo_pkg::*;

  gdo_res_t res, res_q;
  logic     res_valid, res_take;
  logic     out_valid_q;

  gdo_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_day_i     (in_day_i),
    .in_month_i   (in_month_i),
    .in_year_i    (in_year_i),
    .day_offset_i (day_offset_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res)
  );

  // load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_day_o     = res_q.day;
  assign out_month_o   = res_q.month;
  assign out_year_o    = res_q.year;
  assign serial_day_o  = res_q.serial;
  assign date_valid_o  = res_q.date_valid;
  assign range_error_o = res_q.range_error;

endmodule
